@@ hdl/piecewise_linear_interpolator_defines.svh @@
// Assertion macros for the interpolator.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off while in reset.
`define PLIN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while in reset.
`define PLIN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/plin_pkg.sv @@
`timescale 1ns / 1ps

package plin_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned MAG_W  = 16;
  localparam int unsigned PROD_W = 32;
  localparam int unsigned PTS_W  = 4;
  localparam int unsigned CNT_W  = 5;

  localparam logic [CNT_W-1:0] MUL_LAST = 5'd15;
  localparam logic [CNT_W-1:0] DIV_LAST = 5'd31;
  localparam logic [PTS_W-1:0] PTS_RESET = 4'd8;

  typedef enum logic [0:0] {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } plin_action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK,
    ST_CHECK,
    ST_FETCH,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_FINISH
  } plin_state_e;

endpackage

@@ hdl/piecewise_linear_interpolator.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                    Payload
// command   in         start, busy                  action_i, entry_index_i, x_value_i, y_value_i
// result    out        result_strobe_o (one cycle)  y_result_o, saturated_o
// config    in         cfg_valid_i, cfg_ready_o     cfg_data_i (points in use)
//
// Loads may follow each other every cycle while no query is in progress.
// A query walks the breakpoints with k compares (1 to points-1), reading the
// table port once per compare, then fetches the segment's lower point; a
// segment with equal x returns its upper y directly, else a 16-step shift-add
// multiplier and a 32-step restoring divider follow.
// Reset (rst_ni low, async) idles the sequencer and sets points in use to 8;
// the table holds whatever was written. Config waits while busy; the strobe cannot stall.
`include "piecewise_linear_interpolator_defines.svh"

module piecewise_linear_interpolator
  import plin_pkg::*;
#(
  parameter int unsigned TABLE_POINTS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     action_i,
  input  logic [2:0]               entry_index_i,
  input  logic signed [DATA_W-1:0] x_value_i,
  input  logic signed [DATA_W-1:0] y_value_i,
  output logic                     result_strobe_o,
  output logic signed [DATA_W-1:0] y_result_o,
  output logic                     saturated_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [PTS_W-1:0]         cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(TABLE_POINTS);
  localparam logic [6:0]  TP7   = 7'(TABLE_POINTS);

  plin_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic valid_q, valid_d;
  logic [PTS_W-1:0] points_q;

  logic [2*DATA_W-1:0] tbl_q [TABLE_POINTS];
  logic [2*DATA_W-1:0] rd_q;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  logic [6:0]          idx7;
  logic                wr_en;

  logic [IDX_W-1:0] i_q, i_d;
  logic signed [DATA_W-1:0] xq_q, xq_d;
  logic signed [DATA_W-1:0] x1_q, x1_d;
  logic signed [DATA_W-1:0] y1_q, y1_d;
  logic signed [DATA_W-1:0] y0_q, y0_d;
  logic [MAG_W-1:0]  mc_q, mc_d;
  logic [MAG_W-1:0]  den_q, den_d;
  logic [MAG_W-1:0]  rem_q, rem_d;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic neg_q, neg_d;
  logic signed [DATA_W-1:0] yres_q, yres_d;
  logic sat_q, sat_d;

  logic [6:0]       pts7;
  logic [6:0]       act7;
  logic [6:0]       last7;
  logic [IDX_W-1:0] last_idx;

  logic signed [DATA_W-1:0] rd_x, rd_y;
  logic signed [DATA_W:0]   dx, dy, dd;
  logic [MAG_W:0]           mul_sum;
  logic [MAG_W:0]           div_sh;
  logic                     div_ge;
  logic [MAG_W:0]           div_diff;
  logic signed [PROD_W+1:0] q_ext, q_sgn, r_sum;
  logic                     accept;
  logic                     load_acc;
  logic                     query_acc;
  logic                     at_rail;
  logic                     idx_ok;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = !busy;

  assign load_acc  = accept && (plin_action_e'(action_i) == ACT_LOAD);
  assign query_acc = accept && (plin_action_e'(action_i) == ACT_QUERY);

  assign pts7 = 7'(points_q);
  always_comb begin
    priority if (pts7 < 7'd2) begin
      act7 = 7'd2;
    end else if (pts7 > TP7) begin
      act7 = TP7;
    end else begin
      act7 = pts7;
    end
  end
  assign last7    = act7 - 7'd1;
  assign last_idx = last7[IDX_W-1:0];

  assign idx7    = 7'(entry_index_i);
  assign wr_addr = idx7[IDX_W-1:0];
  assign wr_en   = load_acc && (idx7 < TP7);

  assign rd_addr = (state_q == ST_FETCH) ? (i_q - IDX_W'(1)) : i_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_q[wr_addr] <= {x_value_i, y_value_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= tbl_q[rd_addr];
  end

  assign rd_x = rd_q[2*DATA_W-1:DATA_W];
  assign rd_y = rd_q[DATA_W-1:0];

  assign dx = {xq_q[DATA_W-1], xq_q} - {rd_x[DATA_W-1], rd_x};
  assign dy = {y1_q[DATA_W-1], y1_q} - {rd_y[DATA_W-1], rd_y};
  assign dd = {x1_q[DATA_W-1], x1_q} - {rd_x[DATA_W-1], rd_x};

  assign mul_sum  = {1'b0, acc_q[PROD_W-1:MAG_W]} + (acc_q[0] ? {1'b0, mc_q} : '0);
  assign div_sh   = {rem_q, acc_q[PROD_W-1]};
  assign div_ge   = (div_sh >= {1'b0, den_q});
  assign div_diff = div_sh - {1'b0, den_q};

  assign q_ext = $signed({2'b00, acc_q});
  assign q_sgn = neg_q ? -q_ext : q_ext;
  assign r_sum = (PROD_W+2)'(y0_q) + q_sgn;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    valid_d = 1'b0;
    i_d     = i_q;
    xq_d    = xq_q;
    x1_d    = x1_q;
    y1_d    = y1_q;
    y0_d    = y0_q;
    mc_d    = mc_q;
    den_d   = den_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    yres_d  = yres_q;
    sat_d   = sat_q;
    unique case (state_q)
      ST_IDLE: begin
        if (query_acc) begin
          xq_d    = x_value_i;
          i_d     = IDX_W'(1);
          state_d = ST_SEEK;
        end
      end
      ST_SEEK: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if ((i_q < last_idx) && (xq_q > rd_x)) begin
          i_d     = i_q + IDX_W'(1);
          state_d = ST_SEEK;
        end else begin
          x1_d    = rd_x;
          y1_d    = rd_y;
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_SETUP;
      end
      ST_SETUP: begin
        y0_d = rd_y;
        if (x1_q == rd_x) begin
          yres_d  = y1_q;
          sat_d   = 1'b0;
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end else begin
          mc_d    = dy[DATA_W] ? MAG_W'(-dy) : dy[MAG_W-1:0];
          acc_d   = {{(PROD_W-MAG_W){1'b0}}, (dx[DATA_W] ? MAG_W'(-dx) : dx[MAG_W-1:0])};
          den_d   = dd[DATA_W] ? MAG_W'(-dd) : dd[MAG_W-1:0];
          neg_d   = dx[DATA_W] ^ dy[DATA_W] ^ dd[DATA_W];
          cnt_d   = '0;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_d = {mul_sum, acc_q[MAG_W-1:1]};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == MUL_LAST) begin
          cnt_d   = '0;
          rem_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = div_ge ? div_diff[MAG_W-1:0] : div_sh[MAG_W-1:0];
        acc_d = {acc_q[PROD_W-2:0], div_ge};
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == DIV_LAST) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        priority if (r_sum > (PROD_W+2)'(32767)) begin
          yres_d = 16'sh7FFF;
          sat_d  = 1'b1;
        end else if (r_sum < -(PROD_W+2)'(32768)) begin
          yres_d = -16'sh8000;
          sat_d  = 1'b1;
        end else begin
          yres_d = r_sum[DATA_W-1:0];
          sat_d  = 1'b0;
        end
        valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      valid_q  <= 1'b0;
      points_q <= PTS_RESET;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        points_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    xq_q   <= xq_d;
    x1_q   <= x1_d;
    y1_q   <= y1_d;
    y0_q   <= y0_d;
    mc_q   <= mc_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    acc_q  <= acc_d;
    neg_q  <= neg_d;
    yres_q <= yres_d;
    sat_q  <= sat_d;
  end

  assign result_strobe_o = valid_q;
  assign y_result_o      = yres_q;
  assign saturated_o     = sat_q;

  assign at_rail = (y_result_o == 16'sh7FFF) || (y_result_o == -16'sh8000);
  assign idx_ok  = (i_q <= last_idx) && (i_q != '0);

  `PLIN_ASSERT_NEXT(a_load_no_result, load_acc, !result_strobe_o, "load gave a result")
  `PLIN_ASSERT_NEXT(a_query_busy, query_acc, busy, "query not taken")
  `PLIN_ASSERT_NEXT(a_strobe_single, result_strobe_o, !result_strobe_o, "strobe held")
  `PLIN_ASSERT_NOW(a_sat_rail, result_strobe_o && saturated_o, at_rail, "flag off rail")
  `PLIN_ASSERT_NOW(a_index_bound, state_q == ST_CHECK, idx_ok, "search index out of range")

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import plin_pkg::*;

  localparam int unsigned NPTS           = 8;
  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned SETTLE_CYCLES  = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned ITEM_TARGET    = 700;
  localparam longint      Y_MAX          = 32767;
  localparam longint      Y_MIN          = -32768;

  typedef struct {
    plin_action_e             action;
    logic [2:0]               index;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } plin_word_t;

  typedef struct {
    logic signed [DATA_W-1:0] y;
    logic                     sat;
  } interp_out_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     start         = 1'b0;
  logic                     busy;
  logic                     action_i      = 1'b0;
  logic [2:0]               entry_index_i = '0;
  logic signed [DATA_W-1:0] x_value_i     = '0;
  logic signed [DATA_W-1:0] y_value_i     = '0;
  logic                     result_strobe_o;
  logic signed [DATA_W-1:0] y_result_o;
  logic                     saturated_o;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [PTS_W-1:0]         cfg_data_i    = '0;

  logic signed [DATA_W-1:0] bp_x [NPTS];
  logic signed [DATA_W-1:0] bp_y [NPTS];
  logic [PTS_W-1:0]         pts_reg = PTS_RESET;
  int                       plan_x [NPTS];

  plin_word_t  word_q[$];
  interp_out_t interp_exp_q[$];
  plin_word_t  cur_word;

  int unsigned burst_left   = 0;
  int unsigned gap_left     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_cnt      = 0;
  int unsigned load_cnt     = 0;
  int unsigned query_cnt    = 0;
  int unsigned clip_cnt     = 0;
  int unsigned flat_cnt     = 0;
  int unsigned cfg_cnt      = 0;
  int unsigned items_pushed = 0;

  piecewise_linear_interpolator #(
    .TABLE_POINTS(NPTS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .entry_index_i  (entry_index_i),
    .x_value_i      (x_value_i),
    .y_value_i      (y_value_i),
    .result_strobe_o(result_strobe_o),
    .y_result_o     (y_result_o),
    .saturated_o    (saturated_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic interp_out_t interp_predict(input logic signed [DATA_W-1:0] xq);
    interp_out_t res;
    int unsigned n;
    int unsigned seg;
    longint      x0;
    longint      x1;
    longint      y0;
    longint      y1;
    longint      r;
    n = pts_reg;
    if (n < 2) n = 2;
    if (n > NPTS) n = NPTS;
    seg = 1;
    while (seg < n - 1 && xq > bp_x[seg]) seg++;
    x0 = bp_x[seg-1];
    x1 = bp_x[seg];
    y0 = bp_y[seg-1];
    y1 = bp_y[seg];
    res.sat = 1'b0;
    if (x1 == x0) begin
      r = y1;
      flat_cnt++;
    end else begin
      r = y0 + ((longint'(xq) - x0) * (y1 - y0)) / (x1 - x0);
      if (r > Y_MAX) begin
        r = Y_MAX;
        res.sat = 1'b1;
      end
      if (r < Y_MIN) begin
        r = Y_MIN;
        res.sat = 1'b1;
      end
    end
    res.y = r[DATA_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR %s", $time, msg);
    err_cnt++;
  endtask

  task automatic accept_word(input plin_word_t w);
    interp_out_t exp_out;
    if (w.action == ACT_LOAD) begin
      bp_x[w.index] = w.x;
      bp_y[w.index] = w.y;
      load_cnt++;
    end else begin
      exp_out = interp_predict(w.x);
      interp_exp_q.push_back(exp_out);
      query_cnt++;
      if (exp_out.sat) clip_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        accept_word(cur_word);
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (word_q.size() > 0) begin
          cur_word = word_q.pop_front();
          action_i      <= cur_word.action;
          entry_index_i <= cur_word.index;
          x_value_i     <= cur_word.x;
          y_value_i     <= cur_word.y;
          start         <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    interp_out_t exp_out;
    if (rst_ni && result_strobe_o) begin
      if (interp_exp_q.size() == 0) begin
        report_mismatch($sformatf("result %0d sat %0b with no query pending",
                                  y_result_o, saturated_o));
      end else begin
        exp_out = interp_exp_q.pop_front();
        if (y_result_o !== exp_out.y)
          report_mismatch($sformatf("y_result got %0d, expected %0d", y_result_o, exp_out.y));
        if (saturated_o !== exp_out.sat)
          report_mismatch($sformatf("saturated got %0b, expected %0b", saturated_o,
                                    exp_out.sat));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_strobe_o || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("[%0t] ERROR no progress for %0d cycles, %0d results outstanding", $time,
             WATCHDOG_LIMIT, interp_exp_q.size());
    $display("piecewise_linear_interpolator: mismatch");
    $finish;
  end

  function automatic int rand_s16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int clamp16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  task automatic push_load(input int idx, input int x, input int y);
    plin_word_t w;
    w.action = ACT_LOAD;
    w.index  = idx[2:0];
    w.x      = x[DATA_W-1:0];
    w.y      = y[DATA_W-1:0];
    plan_x[idx] = x;
    word_q.push_back(w);
    items_pushed++;
  endtask

  task automatic push_query(input int x, input int y);
    plin_word_t w;
    w.action = ACT_QUERY;
    w.index  = 3'($urandom_range(0, 7));
    w.x      = x[DATA_W-1:0];
    w.y      = y[DATA_W-1:0];
    word_q.push_back(w);
    items_pushed++;
  endtask

  task automatic write_points(input logic [PTS_W-1:0] v);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    pts_reg = v;
    cfg_cnt++;
  endtask

  // hold off until the block is idle with nothing outstanding
  task automatic drain();
    while (word_q.size() != 0 || start || interp_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_ordered_table();
    int xs[$];
    int style;
    int base;
    int stride;
    int acc;
    style = $urandom_range(0, 2);
    base  = rand_s16();
    stride = $urandom_range(1, 8000);
    acc   = base;
    for (int k = 0; k < NPTS; k++) begin
      case (style)
        0: begin
          xs.push_back(rand_s16());
        end
        1: begin
          acc = clamp16(acc + $urandom_range(0, 3));
          xs.push_back(acc);
        end
        default: begin
          xs.push_back(clamp16(base + k * stride));
        end
      endcase
    end
    xs.sort();
    for (int k = 0; k < NPTS; k++)
      push_load(k, xs[k], ($urandom_range(0, 1) == 1) ? rand_s16() : $urandom_range(0, 512) - 256);
  endtask

  function automatic int pick_query_x();
    int a;
    int b;
    a = plan_x[$urandom_range(0, NPTS - 1)];
    b = plan_x[$urandom_range(0, NPTS - 1)];
    case ($urandom_range(0, 5))
      0: return rand_s16();
      1: return ($urandom_range(0, 1) == 1) ? 32767 : -32768;
      2: return a;
      3, 4: return clamp16(a + $urandom_range(0, 16) - 8);
      default: begin
        if (a > b) return $urandom_range(0, a - b) + b;
        return $urandom_range(0, b - a) + a;
      end
    endcase
  endfunction

  initial begin
    logic [PTS_W-1:0] setting;
    logic [PTS_W-1:0] preset [7];
    int unsigned      phase;
    int unsigned      nq;
    preset = '{4'd8, 4'd2, 4'd15, 4'd0, 4'd5, 4'd1, 4'd9};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_points(4'd8);
    push_load(0, -512, 100);
    push_load(1, -256, -32000);
    push_load(2, 256, 32767);
    push_load(3, 257, -32768);
    push_load(4, 1000, 0);
    push_load(5, 2000, -30000);
    push_load(6, 20000, 500);
    push_load(7, 20000, 700);
    push_query(-32768, 32767);
    push_query(-512, -32768);
    push_query(-384, 0);
    push_query(0, 1);
    push_query(257, -1);
    push_query(1500, 0);
    push_query(19999, 0);
    push_query(20000, 0);
    push_query(32767, 0);
    drain();
    write_points(4'd6);
    push_query(32767, 0);
    push_query(1500, 0);
    drain();
    write_points(4'd2);
    push_query(32767, 0);
    drain();
    write_points(4'd0);
    push_query(-32768, 0);
    drain();
    write_points(4'd1);
    push_query(0, 0);
    drain();
    write_points(4'd15);
    push_query(32767, 0);
    drain();

    phase = 0;
    while (items_pushed < ITEM_TARGET) begin
      setting = (phase < 7) ? preset[phase] : 4'($urandom_range(0, 15));
      write_points(setting);
      if ($urandom_range(0, 3) != 0) begin
        load_ordered_table();
        nq = $urandom_range(15, 40);
        repeat (nq) push_query(pick_query_x(), rand_s16());
      end else begin
        nq = $urandom_range(10, 30);
        repeat (nq) begin
          if ($urandom_range(0, 2) == 0)
            push_load($urandom_range(0, NPTS - 1), rand_s16(), rand_s16());
          else
            push_query(pick_query_x(), rand_s16());
        end
      end
      drain();
      phase++;
    end

    $display("covered %0d loads and %0d queries over %0d point-count writes", load_cnt,
             query_cnt, cfg_cnt);
    $display("%0d results clipped, %0d taken from a zero-width segment", clip_cnt, flat_cnt);
    if (err_cnt == 0)
      $display("piecewise_linear_interpolator: match");
    else
      $display("piecewise_linear_interpolator: mismatch");
    $finish;
  end

endmodule
